### src/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent check macros sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Hold cond at every clock edge out of reset.
`define TCW_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("text_console_writer: invariant violated");

// When ante holds, cons must hold in the same cycle.
`define TCW_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text_console_writer: implication violated");

`endif

### src/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;
    localparam int CELL_W          = 16;

    localparam logic [7:0] DEFAULT_COLOR = 8'h07;

    // command codes
    localparam logic [1:0] CMD_WRITE     = 2'd0;
    localparam logic [1:0] CMD_BACKSPACE = 2'd1;
    localparam logic [1:0] CMD_CLEAR     = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    // character codes
    localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
    localparam logic [7:0] BACKSPACE_CODE = 8'h08;
    localparam logic [7:0] BLANK_CODE     = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } tcw_state_t;

endpackage

`default_nettype wire

### src/tcw_screen_ram.sv
// ---------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wen,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] cells_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            cells_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= cells_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// Text screen of character/attribute cells with a write position, scroll,
// backspace, clear and cell readback.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result shows on
// the result ports for exactly one cycle, marked by done; there is no way to
// hold it off, so sample it in that cycle. A printable character, a newline
// that does not scroll, and a backspace leave busy low, so the next command
// can go in on the following edge. A read passes through ST_READ, since the
// screen memory returns registered read data. A clear writes every cell
// once, one per cycle. A write that runs past the last row scrolls: the copy
// walks the memory read-one/write-one per cycle, then blanks the bottom row.
// After reset the block sweeps the memory to blank cells with busy high. The
// color register may be written at any time the block has no command in
// flight; cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  text_color,

    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  char_code,
    input  wire logic [6:0]  read_column,
    input  wire logic [4:0]  read_row,

    // result side
    output logic             done,
    output logic [6:0]       cursor_column,
    output logic [4:0]       cursor_row,
    output logic [10:0]      cursor_offset,
    output logic [15:0]      cell_value,
    output logic             did_scroll
);

    localparam int CELLS      = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int COPY_CELLS = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int COL_W      = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);

    localparam logic [AW-1:0]    COLS_A    = AW'(SCREEN_COLUMNS);
    localparam logic [AW-1:0]    COPY_LAST = AW'(COPY_CELLS);
    localparam logic [AW-1:0]    CELL_LAST = AW'(CELLS - 1);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    tcw_pkg::tcw_state_t state_reg, state_next;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    base_reg, base_next;      // row_reg * SCREEN_COLUMNS
    logic [AW-1:0]    cnt_reg, cnt_next;        // sweep pointer
    logic [7:0]       color_reg;
    logic             done_reg, done_next;
    logic             scroll_reg, scroll_next;
    logic             rd_ok_reg, rd_ok_next;
    logic [15:0]      cell_reg, cell_next;

    // memory port controls
    logic                       mem_wen;
    logic [AW-1:0]              mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    // -----------------------------------------------------------------------
    // Decode of the command at the input
    // -----------------------------------------------------------------------
    logic             accept;
    logic             is_newline;
    logic             line_end;          // write moves to next row
    logic             need_scroll;
    logic [AW-1:0]    cur_offset;
    logic [COL_W-1:0] bs_col;
    logic [ROW_W-1:0] bs_row;
    logic [AW-1:0]    bs_base;
    logic [AW-1:0]    bs_addr;
    logic [31:0]      rd_linear;
    logic             rd_in_range;

    assign accept      = start && (state_reg == tcw_pkg::ST_IDLE);
    assign is_newline  = (char_code == tcw_pkg::NEWLINE_CODE);
    assign line_end    = is_newline || (col_reg == COL_LAST);
    assign need_scroll = (command == tcw_pkg::CMD_WRITE) && line_end
                         && (row_reg == ROW_LAST);
    assign cur_offset  = base_reg + AW'(col_reg);

    // Step back one cell, wrapping to the end of the previous row; stay put
    // at the home position.
    always_comb
    begin
        bs_col  = col_reg;
        bs_row  = row_reg;
        bs_base = base_reg;
        if (col_reg == '0)
        begin
            if (row_reg != '0)
            begin
                bs_col  = COL_LAST;
                bs_row  = row_reg - 1'b1;
                bs_base = base_reg - COLS_A;
            end
        end
        else
        begin
            bs_col = col_reg - 1'b1;
        end
    end

    assign bs_addr = bs_base + AW'(bs_col);

    assign rd_linear   = 32'(read_row) * 32'(SCREEN_COLUMNS) + 32'(read_column);
    assign rd_in_range = (32'(read_column) < 32'(SCREEN_COLUMNS))
                         && (32'(read_row) < 32'(SCREEN_ROWS));

    // -----------------------------------------------------------------------
    // Next state
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        tcw_pkg::CMD_WRITE:
                        begin
                            if (need_scroll)
                            begin
                                state_next = tcw_pkg::ST_SCROLL;
                            end
                        end
                        tcw_pkg::CMD_BACKSPACE: state_next = tcw_pkg::ST_IDLE;
                        tcw_pkg::CMD_CLEAR:     state_next = tcw_pkg::ST_FILL;
                        tcw_pkg::CMD_READ:      state_next = tcw_pkg::ST_READ;
                        default:                state_next = tcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg == COPY_LAST)
                begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // Datapath and memory control
    // -----------------------------------------------------------------------
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        scroll_next = scroll_reg;
        rd_ok_next  = rd_ok_reg;
        cell_next   = cell_reg;
        mem_wen     = 1'b0;
        mem_waddr   = cnt_reg;
        mem_wdata   = {color_reg, tcw_pkg::BLANK_CODE};
        mem_raddr   = cnt_reg;

        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                // blank every cell after reset
                mem_wen   = 1'b1;
                mem_wdata = tcw_pkg::RESET_CELL;
                if (cnt_reg != CELL_LAST)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    scroll_next = need_scroll;
                    cell_next   = '0;
                    unique case (command)
                        tcw_pkg::CMD_WRITE:
                        begin
                            if (!is_newline)
                            begin
                                mem_wen   = 1'b1;
                                mem_waddr = cur_offset;
                                mem_wdata = {color_reg, char_code};
                            end
                            if (line_end)
                            begin
                                col_next = '0;
                                if (need_scroll)
                                begin
                                    // row stays on the last line
                                    cnt_next = '0;
                                end
                                else
                                begin
                                    row_next  = row_reg + 1'b1;
                                    base_next = base_reg + COLS_A;
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next  = col_reg + 1'b1;
                                done_next = 1'b1;
                            end
                        end
                        tcw_pkg::CMD_BACKSPACE:
                        begin
                            col_next  = bs_col;
                            row_next  = bs_row;
                            base_next = bs_base;
                            mem_wen   = 1'b1;
                            mem_waddr = bs_addr;
                            mem_wdata = {color_reg, tcw_pkg::BACKSPACE_CODE};
                            done_next = 1'b1;
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            col_next  = '0;
                            row_next  = '0;
                            base_next = '0;
                            cnt_next  = '0;
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            rd_ok_next = rd_in_range;
                            mem_raddr  = rd_in_range ? rd_linear[AW-1:0] : '0;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                cell_next = rd_ok_reg ? mem_rdata : '0;
                done_next = 1'b1;
            end
            tcw_pkg::ST_SCROLL:
            begin
                // Read one row ahead, write back the cell read last cycle.
                if (cnt_reg != COPY_LAST)
                begin
                    mem_raddr = cnt_reg + COLS_A;
                    cnt_next  = cnt_reg + 1'b1;
                end
                mem_wen   = (cnt_reg != '0);
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = mem_rdata;
            end
            tcw_pkg::ST_FILL:
            begin
                mem_wen = 1'b1;
                if (cnt_reg == CELL_LAST)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tcw_pkg::ST_INIT;
            col_reg    <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
            cnt_reg    <= '0;
            color_reg  <= tcw_pkg::DEFAULT_COLOR;
            done_reg   <= 1'b0;
            scroll_reg <= 1'b0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            scroll_reg <= scroll_next;
            rd_ok_reg  <= rd_ok_next;
            if (cfg_valid)
            begin
                color_reg <= text_color;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // -----------------------------------------------------------------------
    // Screen memory
    // -----------------------------------------------------------------------
    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // -----------------------------------------------------------------------
    // Outputs
    // -----------------------------------------------------------------------
    logic [31:0] col_ext;
    logic [31:0] row_ext;
    logic [31:0] offset_ext;

    assign col_ext    = 32'(col_reg);
    assign row_ext    = 32'(row_reg);
    assign offset_ext = 32'(cur_offset);

    assign cfg_ready     = 1'b1;
    assign busy          = (state_reg != tcw_pkg::ST_IDLE);
    assign done          = done_reg;
    assign cursor_column = col_ext[6:0];
    assign cursor_row    = row_ext[4:0];
    assign cursor_offset = offset_ext[10:0];
    assign cell_value    = cell_reg;
    assign did_scroll    = scroll_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
`include "text_console_writer_assert.svh"

    `TCW_ASSERT_ALWAYS(a_pos_in_range, (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
    `TCW_ASSERT_ALWAYS(a_base_tracks_row, 32'(base_reg) == 32'(row_reg) * 32'(SCREEN_COLUMNS))
    `TCW_ASSERT_IMPLIES(a_done_idle, done_reg, state_reg == tcw_pkg::ST_IDLE)
    `TCW_ASSERT_IMPLIES(a_scroll_last_row, done_reg && scroll_reg, row_reg == ROW_LAST)

endmodule

`default_nettype wire
